@@ hw/rtl/dtf_pkg.sv @@
package dtf_pkg;

  typedef enum logic [2:0] {
    SRC_BOTH     = 3'd0,
    SRC_FAST     = 3'd1,
    SRC_SLOW     = 3'd2,
    SRC_HELD     = 3'd3,
    SRC_FALLBACK = 3'd4
  } source_t;

  // configuration register indexes
  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_FALLBACK = 1'b1;

  localparam logic [15:0]        TIMEOUT_RESET  = 16'd3000;
  localparam logic signed [15:0] FALLBACK_RESET = 16'sd4800;

  // band limits in percent
  localparam logic signed [23:0] BAND_SCALE = 24'sd100;
  localparam logic signed [23:0] BAND_LOW   = 24'sd85;
  localparam logic signed [23:0] BAND_HIGH  = 24'sd115;

  // weighted mix: floor((3*slow + 2*fast + 2) / 5), done on a biased positive value
  localparam logic signed [19:0] WEIGHT_SLOW = 20'sd3;
  localparam logic signed [19:0] WEIGHT_FAST = 20'sd2;
  localparam logic signed [19:0] MIX_BIAS    = 20'sd200002;
  localparam logic [17:0]        MIX_UNBIAS  = 18'd40000;
  localparam logic [39:0]        DIV5_MULT   = 40'd838861;
  localparam int                 DIV5_SHIFT  = 22;

endpackage

@@ hw/rtl/dtf_median.sv @@
module dtf_median #(
  parameter int WINDOW = 5
) (
  input  logic signed [15:0] win [WINDOW],
  output logic signed [15:0] median
);

  localparam int RANK_W = $clog2(WINDOW + 1);
  localparam int K_LO   = (WINDOW - 1) / 2;
  localparam int K_HI   = WINDOW / 2;

  logic [RANK_W-1:0]  rank [WINDOW];
  logic signed [15:0] sel_lo;
  logic signed [15:0] sel_hi;
  logic signed [16:0] mid_sum;

  // rank of each entry; ties broken by position so every rank is unique
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if ((win[j] < win[i]) || ((j < i) && (win[j] == win[i]))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  always_comb begin
    sel_lo = '0;
    sel_hi = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == RANK_W'(K_LO)) begin
        sel_lo = sel_lo | win[i];
      end
      if (rank[i] == RANK_W'(K_HI)) begin
        sel_hi = sel_hi | win[i];
      end
    end
  end

  // odd window: both picks are the same entry, so the mean is that entry
  assign mid_sum = 17'(sel_lo) + 17'(sel_hi);
  assign median  = 16'(mid_sum >>> 1);

endmodule

@@ hw/rtl/dual_thermocouple_fusion_median.sv @@
// An input beat passes through the input register and then the result register.
// Throughput: one sample per cycle while out_stall is low; fusion, window write and median are
// combinational between the input register and the result register.
// Reset (rst, synchronous): window, median history, write index and timer cleared;
// registers back to 3000 ms timeout and 4800 fallback.
module dual_thermocouple_fusion_median #(
  parameter int WINDOW = 5
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_write_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] fast_raw,
  input  logic signed [15:0] slow_raw,
  input  logic               fast_comm_fail,
  input  logic               fast_open,
  input  logic               fast_short,
  input  logic               slow_comm_fail,
  input  logic               slow_open,
  input  logic               slow_short,
  input  logic [31:0]        now_ms,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] filtered_temp,
  output logic signed [15:0] fused_temp,
  output logic [2:0]         source
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // configuration
  logic [15:0]        timeout;
  logic signed [15:0] fallback;

  // input register
  logic               in_full;
  logic signed [15:0] fast_q;
  logic signed [15:0] slow_q;
  logic               fast_flag_q;
  logic               slow_flag_q;
  logic [31:0]        now_q;

  // state
  logic signed [15:0] last_filtered;
  logic signed [15:0] window [WINDOW];
  logic [IDX_W-1:0]   write_index;
  logic [IDX_W-1:0]   write_index_next;
  logic [31:0]        timer_start;

  // result register
  logic signed [15:0] filtered_q;
  logic signed [15:0] fused_q;
  dtf_pkg::source_t   source_q;

  logic               take;
  logic               advance;

  logic signed [23:0] fast_pct;
  logic signed [23:0] slow_pct;
  logic signed [23:0] last_lo;
  logic signed [23:0] last_hi;
  logic               fast_bad;
  logic               slow_bad;
  logic signed [19:0] mix_biased;
  logic [39:0]        mix_prod;
  logic [17:0]        mix_quot;
  logic signed [15:0] mix;
  logic [31:0]        elapsed;
  logic signed [15:0] fused;
  dtf_pkg::source_t   src;
  logic signed [15:0] win_new [WINDOW];
  logic signed [15:0] median;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign take     = in_valid && !in_stall;

  // tolerance band around the last median
  always_comb begin
    fast_pct = 24'(fast_q) * dtf_pkg::BAND_SCALE;
    slow_pct = 24'(slow_q) * dtf_pkg::BAND_SCALE;
    last_lo  = 24'(last_filtered) * dtf_pkg::BAND_LOW;
    last_hi  = 24'(last_filtered) * dtf_pkg::BAND_HIGH;
    fast_bad = fast_flag_q && ((fast_pct < last_lo) || (fast_pct > last_hi));
    slow_bad = slow_flag_q && ((slow_pct < last_lo) || (slow_pct > last_hi));
  end

  // weighted mix, rounded half up; divide by 5 through a reciprocal multiply
  always_comb begin
    mix_biased = 20'(slow_q) * dtf_pkg::WEIGHT_SLOW
               + 20'(fast_q) * dtf_pkg::WEIGHT_FAST
               + dtf_pkg::MIX_BIAS;
    mix_prod   = 40'(unsigned'(mix_biased)) * dtf_pkg::DIV5_MULT;
    mix_quot   = mix_prod[dtf_pkg::DIV5_SHIFT +: 18];
    mix        = 16'(mix_quot - dtf_pkg::MIX_UNBIAS);
  end

  assign elapsed = now_q - timer_start;

  always_comb begin
    if (fast_bad && slow_bad) begin
      if (elapsed >= 32'(timeout)) begin
        fused = fallback;
        src   = dtf_pkg::SRC_FALLBACK;
      end else begin
        fused = last_filtered;
        src   = dtf_pkg::SRC_HELD;
      end
    end else if (slow_bad) begin
      fused = fast_q;
      src   = dtf_pkg::SRC_FAST;
    end else if (fast_bad) begin
      fused = slow_q;
      src   = dtf_pkg::SRC_SLOW;
    end else begin
      fused = mix;
      src   = dtf_pkg::SRC_BOTH;
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      win_new[i] = (write_index == IDX_W'(i)) ? fused : window[i];
    end
    if (write_index == IDX_W'(WINDOW - 1)) begin
      write_index_next = '0;
    end else begin
      write_index_next = write_index + IDX_W'(1);
    end
  end

  dtf_median #(
    .WINDOW (WINDOW)
  ) u_median (
    .win    (win_new),
    .median (median)
  );

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout       <= dtf_pkg::TIMEOUT_RESET;
      fallback      <= dtf_pkg::FALLBACK_RESET;
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      last_filtered <= '0;
      write_index   <= '0;
      timer_start   <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          dtf_pkg::CFG_TIMEOUT:  timeout  <= cfg_data;
          dtf_pkg::CFG_FALLBACK: fallback <= cfg_data;
        endcase
      end
      in_full <= take || (in_full && !advance);
      if (advance) begin
        out_valid     <= 1'b1;
        last_filtered <= median;
        write_index   <= write_index_next;
        for (int i = 0; i < WINDOW; i++) begin
          window[i] <= win_new[i];
        end
        if (!(fast_bad && slow_bad)) begin
          timer_start <= now_q;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      fast_q      <= fast_raw;
      slow_q      <= slow_raw;
      fast_flag_q <= fast_comm_fail || fast_open || fast_short || (fast_raw == 16'sd0);
      slow_flag_q <= slow_comm_fail || slow_open || slow_short || (slow_raw == 16'sd0);
      now_q       <= now_ms;
    end
    if (advance) begin
      filtered_q <= median;
      fused_q    <= fused;
      source_q   <= src;
    end
  end

  assign filtered_temp = filtered_q;
  assign fused_temp    = fused_q;
  assign source        = 3'(source_q);

endmodule
